// File: sv/rgb_to_hsv_pixel_assert.svh
// Assertion macros shared by the rgb_to_hsv_pixel RTL.
// Depends on nothing; included by the modules that carry checks.
`ifndef RGB_TO_HSV_PIXEL_ASSERT_SVH
`define RGB_TO_HSV_PIXEL_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RHSV_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rgb_to_hsv_pixel: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RHSV_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rgb_to_hsv_pixel: next-cycle check failed");

`endif

// File: sv/rhsv_pkg.sv
// Package for the RGB to HSV pixel converter: payload types, work item
// format, divider pipeline stage format and fixed constants. No dependencies.
package rhsv_pkg;

  localparam int CHAN_W   = 8;
  localparam int HUE_W    = 15;
  localparam int SAT_W    = 13;
  localparam int HNUM_W   = 24;   // 7680 * 1530 + 255 fits in 24 bits
  localparam int SNUM_W   = 21;   // 8192 * 255 + 255 fits in 21 bits
  localparam int DIV_W    = 9;    // twice an 8-bit channel value
  localparam int ARG_W    = 11;   // sector numerator, at most six times the spread

  localparam int HUE_QW   = 15;   // quotient bits of the hue division
  localparam int SAT_QW   = 13;   // quotient bits of the saturation division

  localparam logic [HUE_W-1:0] HUE_TURN    = 15'd23040;
  localparam logic [HUE_W-1:0] HUE_BASE_R  = 15'd0;
  localparam logic [HUE_W-1:0] HUE_BASE_G  = 15'd3840;   // 120 degrees minus 60
  localparam logic [HUE_W-1:0] HUE_BASE_B  = 15'd11520;  // 240 degrees minus 60
  localparam logic [SAT_W-1:0] SAT_ONE     = 13'd4096;

  localparam int RHSV_FIFO_DEPTH = 4;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rhsv_in_t;

  typedef struct packed {
    logic [HUE_W-1:0]  hue_angle;
    logic [SAT_W-1:0]  sat_level;
    logic [CHAN_W-1:0] val_level;
  } rhsv_out_t;

  // Classified pixel: both divisions set up, ready for the back end.
  typedef struct packed {
    logic [HNUM_W-1:0] hue_num;
    logic [DIV_W-1:0]  hue_div;
    logic [HUE_W-1:0]  hue_base;
    logic              hue_zero;
    logic [SNUM_W-1:0] sat_num;
    logic [DIV_W-1:0]  sat_div;
    logic              sat_zero;
    logic [CHAN_W-1:0] val;
  } rhsv_work_t;

  // One stage of the restoring divider pipeline.
  typedef struct packed {
    logic [HNUM_W-1:0] hrem;
    logic [HUE_QW-1:0] hq;
    logic [DIV_W-1:0]  hdiv;
    logic [HUE_W-1:0]  hbase;
    logic              hzero;
    logic [SNUM_W-1:0] srem;
    logic [SAT_QW-1:0] sq;
    logic [DIV_W-1:0]  sdiv;
    logic              szero;
    logic [CHAN_W-1:0] val;
  } rhsv_stg_t;

endpackage

// File: sv/rhsv_front.sv
// Front end of the RGB to HSV converter: finds max, min, spread and sector
// and sets up the hue and saturation divisions. Depends on rhsv_pkg.
module rhsv_front import rhsv_pkg::*; (
  input  rhsv_in_t   pix,
  output rhsv_work_t work
);

  logic [CHAN_W-1:0] mx, mn, d;
  logic [ARG_W-1:0]  arg;
  logic [ARG_W-1:0]  d6;
  logic [HNUM_W-1:0] arg_w;

  always_comb begin
    mx = pix.red;
    mn = pix.red;
    if (pix.green > mx) mx = pix.green;
    if (pix.blue  > mx) mx = pix.blue;
    if (pix.green < mn) mn = pix.green;
    if (pix.blue  < mn) mn = pix.blue;
    d  = mx - mn;
    d6 = (ARG_W'(d) << 2) + (ARG_W'(d) << 1);

    // Each sector numerator is shifted to be non-negative; the base offset, or the
    // full-turn wrap for red, absorbs the shift so the quotient stays a floor of a positive value.
    if (mx == pix.red) begin
      if (pix.green >= pix.blue) begin
        arg = ARG_W'(pix.green) - ARG_W'(pix.blue);
      end else begin
        arg = d6 - (ARG_W'(pix.blue) - ARG_W'(pix.green));
      end
      work.hue_base = HUE_BASE_R;
    end else if (mx == pix.green) begin
      arg = ARG_W'(pix.blue) + ARG_W'(d) - ARG_W'(pix.red);
      work.hue_base = HUE_BASE_G;
    end else begin
      arg = ARG_W'(pix.red) + ARG_W'(d) - ARG_W'(pix.green);
      work.hue_base = HUE_BASE_B;
    end

    // 7680 = 8192 - 512, plus d for round-half-up against a divisor of 2d.
    arg_w         = HNUM_W'(arg);
    work.hue_num  = (arg_w << 13) - (arg_w << 9) + HNUM_W'(d);
    work.hue_div  = {d, 1'b0};
    work.hue_zero = (d == '0);
    work.sat_num  = (SNUM_W'(d) << 13) + SNUM_W'(mx);
    work.sat_div  = {mx, 1'b0};
    work.sat_zero = (mx == '0);
    work.val      = mx;
  end

endmodule

// File: sv/rhsv_fifo.sv
// Short queue between the front and back ends of the RGB to HSV converter.
// Depends on rhsv_pkg and the assertion macro header.
`include "rgb_to_hsv_pixel_assert.svh"

module rhsv_fifo import rhsv_pkg::*; #(
  parameter int DEPTH = RHSV_FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  rhsv_work_t wdata,
  input  logic       pop,
  output rhsv_work_t rdata,
  output logic       full,
  output logic       empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rhsv_work_t        mem_r [DEPTH];
  logic [PW-1:0]     wptr_r, wptr_nxt;
  logic [PW-1:0]     rptr_r, rptr_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  `RHSV_ASSERT_IMP(a_no_push_full, clk, rst_n, push, !full)
  `RHSV_ASSERT_IMP(a_no_pop_empty, clk, rst_n, pop, !empty)
  `RHSV_ASSERT_NXT(a_cnt_up, clk, rst_n, push && !pop, cnt_r == $past(cnt_r) + 1'b1)

endmodule

// File: sv/rhsv_back.sv
// Back end of the RGB to HSV converter: a restoring divider pipeline (one hue
// quotient bit per stage, saturation bits only in the 13 low bit positions), then the output register.
// Depends on rhsv_pkg and the assertion macro header.
`include "rgb_to_hsv_pixel_assert.svh"

module rhsv_back import rhsv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  rhsv_work_t head,
  input  logic       q_empty,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output rhsv_out_t  out_pix
);

  localparam int NSTG = HUE_QW;

  logic            adv;
  logic [NSTG-1:0] vld_r;
  rhsv_stg_t       src     [NSTG];
  rhsv_stg_t       stg_r   [NSTG];
  rhsv_stg_t       stg_nxt [NSTG];
  logic            out_valid_r;
  rhsv_out_t       out_pix_r, out_pix_nxt;
  logic [HUE_W:0]  hue_sum;

  // The whole pipeline moves together unless a finished result is held.
  assign adv   = !out_valid_r || !out_stall;
  assign q_pop = adv && !q_empty;

  always_comb begin
    src[0].hrem  = head.hue_num;
    src[0].hq    = '0;
    src[0].hdiv  = head.hue_div;
    src[0].hbase = head.hue_base;
    src[0].hzero = head.hue_zero;
    src[0].srem  = head.sat_num;
    src[0].sq    = '0;
    src[0].sdiv  = head.sat_div;
    src[0].szero = head.sat_zero;
    src[0].val   = head.val;
  end

  for (genvar k = 1; k < NSTG; k++) begin : g_src
    assign src[k] = stg_r[k-1];
  end

  for (genvar k = 0; k < NSTG; k++) begin : g_stg
    localparam int QB = NSTG - 1 - k;
    logic [HNUM_W-1:0] hsh;
    logic [SNUM_W-1:0] srem_n;
    logic [SAT_QW-1:0] sq_n;

    assign hsh = HNUM_W'(src[k].hdiv) << QB;

    if (QB < SAT_QW) begin : g_sat
      logic [SNUM_W-1:0] ssh;
      assign ssh = SNUM_W'(src[k].sdiv) << QB;
      always_comb begin
        srem_n = src[k].srem;
        sq_n   = src[k].sq;
        if (src[k].srem >= ssh) begin
          srem_n   = src[k].srem - ssh;
          sq_n[QB] = 1'b1;
        end
      end
    end else begin : g_nosat
      assign srem_n = src[k].srem;
      assign sq_n   = src[k].sq;
    end

    always_comb begin
      stg_nxt[k]      = src[k];
      stg_nxt[k].srem = srem_n;
      stg_nxt[k].sq   = sq_n;
      if (src[k].hrem >= hsh) begin
        stg_nxt[k].hrem   = src[k].hrem - hsh;
        stg_nxt[k].hq[QB] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
  end

  always_comb begin
    hue_sum = (HUE_W + 1)'(stg_r[NSTG-1].hbase) + (HUE_W + 1)'(stg_r[NSTG-1].hq);
    if (hue_sum >= (HUE_W + 1)'(HUE_TURN)) begin
      hue_sum = hue_sum - (HUE_W + 1)'(HUE_TURN);
    end
    out_pix_nxt.hue_angle = stg_r[NSTG-1].hzero ? '0 : hue_sum[HUE_W-1:0];
    out_pix_nxt.sat_level = stg_r[NSTG-1].szero ? '0 : stg_r[NSTG-1].sq;
    out_pix_nxt.val_level = stg_r[NSTG-1].val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[NSTG-2:0], q_pop};
      out_valid_r <= vld_r[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pix_r <= out_pix_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pix   = out_pix_r;

  `RHSV_ASSERT_IMP(a_hue_range, clk, rst_n, out_valid_r, out_pix_r.hue_angle < HUE_TURN)
  `RHSV_ASSERT_IMP(a_sat_range, clk, rst_n, out_valid_r, out_pix_r.sat_level <= SAT_ONE)
  `RHSV_ASSERT_NXT(a_freeze, clk, rst_n, out_valid_r && out_stall, $stable(vld_r))

endmodule

// File: sv/rgb_to_hsv_pixel.sv
// Top level of the RGB to HSV pixel converter.
// Depends on rhsv_pkg, rhsv_front, rhsv_fifo and rhsv_back.
//
//   channel   direction   handshake              payload
//   in_       input       in_valid / in_stall    in_pix  (rhsv_in_t: red, green, blue)
//   out_      output      out_valid / out_stall  out_pix (rhsv_out_t: hue, sat, value)
//
// One pixel is accepted per clock and one result leaves per clock when neither
// side stalls. From an input transfer to its output, a pixel passes through
// the queue storage, 15 divider stages (one quotient bit of the hue division
// each, the 13-bit saturation division riding alongside), and the output register.
// Reset is synchronous and active low; it empties the queue and clears the
// valid bits of the divider pipeline and of the output register, nothing else.
// A stall on the output while a result is waiting freezes the divider pipeline;
// the queue keeps taking pixels until it is full, and only then is in_stall raised.
module rgb_to_hsv_pixel import rhsv_pkg::*; #(
  parameter int FIFO_DEPTH = RHSV_FIFO_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  rhsv_in_t  in_pix,
  output logic      out_valid,
  input  logic      out_stall,
  output rhsv_out_t out_pix
);

  rhsv_work_t work_in;
  rhsv_work_t work_head;
  logic       q_full;
  logic       q_empty;
  logic       q_push;
  logic       q_pop;

  // The front end classifies the pixel in the cycle of its transfer, and the
  // classified item goes straight into the queue.
  rhsv_front u_front (
    .pix  (in_pix),
    .work (work_in)
  );

  // The stall depends only on the queue fill, never on in_valid.
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  rhsv_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (work_in),
    .pop   (q_pop),
    .rdata (work_head),
    .full  (q_full),
    .empty (q_empty)
  );

  // The back end pulls one item per cycle from a non-empty queue while its output is free to move.
  rhsv_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (work_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_pix   (out_pix)
  );

endmodule
